@@ hw/rtl/msp_pkg.sv @@
// Shared types and constants for the matrix sum-product block.
// Depends on nothing; every other file of the block imports it.
package msp_pkg;

    localparam int WORD_W = 32;
    localparam int DIM_W  = 4;   // width of a size register
    localparam int IDX_W  = 3;   // width of a row / column / inner index

    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [WORD_W-1:0] t_sword;
    typedef logic [DIM_W-1:0]         t_dim;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [1:0]               t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_ROW_COUNT   = 2'd0;
    localparam t_cfg_idx REG_INNER_COUNT = 2'd1;
    localparam t_cfg_idx REG_COL_COUNT   = 2'd2;

    localparam t_dim DIM_RESET = 4'd8;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // one multiply-accumulate step issued by the controller
    typedef struct packed {
        logic issue;
        logic first;   // first inner term: clear the accumulator
        logic last;    // last inner term: emit the element
        logic final_el; // last element of the result matrix
        t_idx row;
        t_idx col;
        t_idx k;
    } t_cmd;

    typedef struct packed {
        logic en;        // pipeline may advance
        logic pipe_busy; // reads or products still in flight
    } t_stat;

endpackage

@@ hw/rtl/msp_in_if.sv @@
// Input channel: valid/ready handshake with one element pair per transaction.
// Depends on msp_pkg.
interface msp_in_if
    import msp_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   side;
    t_sword first_value;
    t_sword second_value;
    logic   last_of_side;

    modport source (output valid, side, first_value, second_value, last_of_side,
                    input ready);
    modport sink   (input valid, side, first_value, second_value, last_of_side,
                    output ready);
endinterface

@@ hw/rtl/msp_out_if.sv @@
// Output channel: valid/ready handshake with one result element per transaction.
// Depends on msp_pkg.
interface msp_out_if
    import msp_pkg::*;
();
    logic   valid;
    logic   ready;
    t_sword product_value;
    t_idx   out_row;
    t_idx   out_col;
    logic   last_result;

    modport source (output valid, product_value, out_row, out_col, last_result,
                    input ready);
    modport sink   (input valid, product_value, out_row, out_col, last_result,
                    output ready);
endinterface

@@ hw/rtl/msp_ctrl.sv @@
// Controller: accepts input transactions and walks the row/column/inner loops.
// Depends on msp_pkg; drives msp_dp through t_cmd and watches t_stat.
module msp_ctrl
    import msp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_side,
    input  logic  i_last,
    input  t_dim  i_rows,
    input  t_dim  i_inner,
    input  t_dim  i_cols,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_ready
);

    t_state r_state, n_state;
    t_idx   r_row, n_row;
    t_idx   r_col, n_col;
    t_idx   r_k, n_k;

    logic k_end, col_end, row_end;

    assign k_end   = ({1'b0, r_k}   == i_inner - 4'd1);
    assign col_end = ({1'b0, r_col} == i_cols  - 4'd1);
    assign row_end = ({1'b0, r_row} == i_rows  - 4'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept && i_side == SIDE_RIGHT && i_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.issue && o_cmd.final_el) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready        = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.first    = (r_k == '0);
        o_cmd.last     = k_end;
        o_cmd.final_el = k_end && col_end && row_end;
        o_cmd.row      = r_row;
        o_cmd.col      = r_col;
        o_cmd.k        = r_k;
        unique case (r_state)
            ST_IDLE:  o_ready     = 1'b1;
            ST_RUN:   o_cmd.issue = i_stat.en;
            ST_DRAIN: ;
            default:  ;
        endcase
    end

    // loop counters: advance inner, then column, then row
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_k   = r_k;
        if (r_state != ST_RUN) begin
            n_row = '0;
            n_col = '0;
            n_k   = '0;
        end else if (o_cmd.issue) begin
            if (!k_end) begin
                n_k = r_k + 3'd1;
            end else begin
                n_k = '0;
                if (!col_end) begin
                    n_col = r_col + 3'd1;
                end else begin
                    n_col = '0;
                    n_row = r_row + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

endmodule

@@ hw/rtl/msp_dp.sv @@
// Datapath: sum stores, fill counters, read/multiply/accumulate pipeline, result register.
// Depends on msp_pkg and msp_out_if; commanded by msp_ctrl.
module msp_dp
    import msp_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_ld_valid,
    input  logic  i_side,
    input  logic  i_last,
    input  t_word i_first_value,
    input  t_word i_second_value,
    input  t_dim  i_rows,
    input  t_dim  i_inner,
    input  t_dim  i_cols,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    msp_out_if.source o_out
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);

    t_word r_left_mem  [DEPTH];
    t_word r_right_mem [DEPTH];

    logic [FW-1:0] r_left_fill, r_right_fill;
    logic [7:0]    left_lim, right_lim, l_addr, r_addr;
    logic          wr_left, wr_right;
    t_word         sum;
    logic          en;

    // pipeline registers
    logic  r_s1_valid, r_s1_first, r_s1_last, r_s1_final;
    t_idx  r_s1_row, r_s1_col;
    t_word r_l_rd, r_r_rd;
    logic  r_s2_valid, r_s2_first, r_s2_last, r_s2_final;
    t_idx  r_s2_row, r_s2_col;
    t_word r_prod;
    t_word r_acc, n_acc;
    logic  r_out_valid, r_out_last;
    t_idx  r_out_row, r_out_col;
    t_word r_out_value;

    assign sum       = i_first_value + i_second_value;
    assign left_lim  = 8'(i_rows)  * 8'(i_inner);
    assign right_lim = 8'(i_inner) * 8'(i_cols);
    assign wr_left   = i_ld_valid && i_side == SIDE_LEFT  && 8'(r_left_fill)  < left_lim;
    assign wr_right  = i_ld_valid && i_side == SIDE_RIGHT && 8'(r_right_fill) < right_lim;

    assign l_addr = 8'(i_cmd.row) * 8'(i_inner) + 8'(i_cmd.k);
    assign r_addr = 8'(i_cmd.k)   * 8'(i_cols)  + 8'(i_cmd.col);

    // hold the whole pipeline while a result waits on the output
    assign en               = !r_out_valid || o_out.ready;
    assign o_stat.en        = en;
    assign o_stat.pipe_busy = r_s1_valid || r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_fill  <= '0;
            r_right_fill <= '0;
        end else if (i_ld_valid) begin
            if (i_side == SIDE_LEFT) begin
                if (i_last) begin
                    r_left_fill <= '0;
                end else if (wr_left) begin
                    r_left_fill <= r_left_fill + FW'(1);
                end
            end else begin
                if (i_last) begin
                    r_right_fill <= '0;
                end else if (wr_right) begin
                    r_right_fill <= r_right_fill + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_left) begin
            r_left_mem[r_left_fill[AW-1:0]] <= sum;
        end
        if (en) begin
            r_l_rd <= r_left_mem[l_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_right) begin
            r_right_mem[r_right_fill[AW-1:0]] <= sum;
        end
        if (en) begin
            r_r_rd <= r_right_mem[r_addr[AW-1:0]];
        end
    end

    assign n_acc = (r_s2_first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_cmd.issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_first <= i_cmd.first;
            r_s1_last  <= i_cmd.last;
            r_s1_final <= i_cmd.final_el;
            r_s1_row   <= i_cmd.row;
            r_s1_col   <= i_cmd.col;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_final <= r_s1_final;
            r_s2_row   <= r_s1_row;
            r_s2_col   <= r_s1_col;
            r_prod     <= r_l_rd * r_r_rd;
            if (r_s2_valid) begin
                r_acc <= n_acc;
            end
            if (r_s2_valid && r_s2_last) begin
                r_out_value <= n_acc;
                r_out_row   <= r_s2_row;
                r_out_col   <= r_s2_col;
                r_out_last  <= r_s2_final;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.product_value = $signed(r_out_value);
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.last_result   = r_out_last;

endmodule

@@ hw/rtl/matrix_sum_product_top.sv @@
// Top level of the matrix sum-product block: size registers, controller, datapath.
// Depends on msp_pkg, msp_in_if, msp_out_if, msp_ctrl and msp_dp.

// Computes Y = (A+B)*(C+D) on signed 32-bit matrices, all arithmetic wrapping
// modulo 2^32. Send A,B pairs (side 0) and then C,D pairs (side 1) in row-major
// order, one pair per transaction; last_of_side closes a side. Pairs beyond the
// configured size are dropped. Load transactions are taken one per cycle while
// the block is idle. The transaction that closes the right side starts the
// product: a single multiply-accumulate unit runs one inner term per cycle
// while the pipeline is not stalled; each term passes the read and product
// registers into the accumulator, and Y comes out in row-major order
// (backpressure stalls the whole pipeline). No input is taken while the
// product runs; ready returns in the cycle after the last element turns
// valid. Size registers read 0 as 1 and values above MAX_DIM as MAX_DIM;
// write them only while the block is idle. The sum stores need no clearing
// after reset; reading a never-written entry gives an undefined value.
module matrix_sum_product_top
    import msp_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_dim     i_cfg_data,
    msp_in_if.sink    i_in,
    msp_out_if.source o_out
);

    t_dim  r_row_count, r_inner_count, r_col_count;
    t_dim  rows, inner, cols;
    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    // clamp a size register to 1..MAX_DIM
    function automatic t_dim eff_dim(input t_dim v);
        t_dim r;
        if (v == '0) begin
            r = 4'd1;
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign rows  = eff_dim(r_row_count);
    assign inner = eff_dim(r_inner_count);
    assign cols  = eff_dim(r_col_count);

    // size registers; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= DIM_RESET;
            r_inner_count <= DIM_RESET;
            r_col_count   <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                REG_INNER_COUNT: r_inner_count <= i_cfg_data;
                REG_COL_COUNT:   r_col_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_in.valid && i_in.ready;

    msp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_side  (i_in.side),
        .i_last  (i_in.last_of_side),
        .i_rows  (rows),
        .i_inner (inner),
        .i_cols  (cols),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (i_in.ready)
    );

    msp_dp #(
        .MAX_DIM(MAX_DIM)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ld_valid    (accept),
        .i_side        (i_in.side),
        .i_last        (i_in.last_of_side),
        .i_first_value (t_word'(i_in.first_value)),
        .i_second_value(t_word'(i_in.second_value)),
        .i_rows        (rows),
        .i_inner       (inner),
        .i_cols        (cols),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out         (o_out)
    );

`ifndef NO_ASSERTIONS
    // no load transaction while multiply-accumulate reads are in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !stat.pipe_busy)
        else $error("input ready while product pipeline busy");

    // closing the right side stops intake on the next cycle
    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.side == SIDE_RIGHT && i_in.last_of_side) |=> !i_in.ready)
        else $error("input still ready after product start");

    // the final result element sits at the bottom right corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_result) |->
            ({1'b0, o_out.out_row} == rows - 4'd1 && {1'b0, o_out.out_col} == cols - 4'd1))
        else $error("last result not at final row and column");

    // a step is only issued when the pipeline may advance and input is not ready
    a_issue_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> (stat.en && !i_in.ready))
        else $error("step issued while stalled or idle");
`endif

endmodule

@@ tb/matrix_sum_product_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for matrix_sum_product_top: sends A,B and C,D element pairs,
// predicts every element of (A+B)*(C+D) and checks the result stream in order.
// Depends on msp_pkg, msp_in_if, msp_out_if and the RTL of the block.
module matrix_sum_product_top_tb;
    import msp_pkg::*;

    localparam int MAX_DIM       = 8;
    localparam int STORE_DEPTH   = 64;
    localparam int RANDOM_PAIRS  = 260;
    localparam int SETTLE_CYCLES = 16;    // pipeline latency plus margin
    localparam int STALL_LIMIT   = 4000;  // cycles with no transaction on either side
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic   side;
        t_sword first_value;
        t_sword second_value;
        logic   last_of_side;
    } t_pair;

    typedef struct packed {
        t_sword product_value;
        t_idx   out_row;
        t_idx   out_col;
        logic   last_result;
    } t_product_elem;

    // Keeps its own copy of both sum stores, fill counts and sizes; every right
    // side that closes pushes the whole product matrix onto expected_elems.
    class matrix_product_board;
        t_word                  left_sum [STORE_DEPTH];
        t_word                  right_sum [STORE_DEPTH];
        logic [STORE_DEPTH-1:0] left_written;
        logic [STORE_DEPTH-1:0] right_written;
        logic [6:0]             left_fill;
        logic [6:0]             right_fill;
        t_dim                   row_count;
        t_dim                   inner_count;
        t_dim                   col_count;
        t_product_elem          expected_elems [$];
        int                     mismatches;

        function new();
            left_written  = '0;
            right_written = '0;
            left_fill     = '0;
            right_fill    = '0;
            row_count     = DIM_RESET;
            inner_count   = DIM_RESET;
            col_count     = DIM_RESET;
            mismatches    = 0;
        endfunction

        // 0 acts as 1, anything above MAX_DIM as MAX_DIM
        function int unsigned span(t_dim d);
            if (d == 0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        function int unsigned left_need();
            return span(row_count) * span(inner_count);
        endfunction

        function int unsigned right_need();
            return span(inner_count) * span(col_count);
        endfunction

        function void set_size(t_cfg_idx idx, t_dim value);
            case (idx)
                REG_ROW_COUNT:   row_count   = value;
                REG_INNER_COUNT: inner_count = value;
                REG_COL_COUNT:   col_count   = value;
                default: ;
            endcase
        endfunction

        function void note_pair(t_pair p);
            t_word       sum;
            t_word       acc;
            int unsigned n_rows;
            int unsigned n_inner;
            int unsigned n_cols;
            n_rows  = span(row_count);
            n_inner = span(inner_count);
            n_cols  = span(col_count);
            sum     = p.first_value + p.second_value;
            if (p.side == SIDE_LEFT) begin
                if (left_fill < left_need()) begin
                    left_sum[left_fill[5:0]]     = sum;
                    left_written[left_fill[5:0]] = 1'b1;
                    left_fill++;
                end
                if (p.last_of_side) left_fill = '0;
                return;
            end
            if (right_fill < right_need()) begin
                right_sum[right_fill[5:0]]     = sum;
                right_written[right_fill[5:0]] = 1'b1;
                right_fill++;
            end
            if (!p.last_of_side) return;
            for (int i = 0; i < n_rows; i++) begin
                for (int j = 0; j < n_cols; j++) begin
                    acc = '0;
                    for (int k = 0; k < n_inner; k++)
                        acc = acc + left_sum[(i * n_inner + k) % STORE_DEPTH]
                                  * right_sum[(k * n_cols + j) % STORE_DEPTH];
                    expected_elems.push_back('{t_sword'(acc), t_idx'(i), t_idx'(j),
                                               (i == n_rows - 1) && (j == n_cols - 1)});
                end
            end
            right_fill = '0;
        endfunction

        function void check_result(t_product_elem got);
            t_product_elem want;
            if (expected_elems.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result value %0d row %0d col %0d last %0b",
                             $time, got.product_value, got.out_row, got.out_col,
                             got.last_result);
                return;
            end
            want = expected_elems.pop_front();
            if (got.product_value !== want.product_value || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: want %0d (%0d,%0d) last %0b, got %0d (%0d,%0d) last %0b",
                             $time, want.product_value, want.out_row, want.out_col,
                             want.last_result, got.product_value, got.out_row,
                             got.out_col, got.last_result);
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_dim     i_cfg_data;

    msp_in_if  pair_ch ();
    msp_out_if product_ch ();

    matrix_sum_product_top #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (pair_ch),
        .o_out      (product_ch)
    );

    matrix_product_board products = new();

    int send_idle_pct = 24;
    int recv_idle_pct = 64;
    int random_pairs  = 0;
    int quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: decide ready at every falling edge so that stalls land on any
    // phase of the product, including its first and last element.
    initial begin
        product_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            product_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each result transaction against the oldest expected element.
    always @(posedge i_clk) begin
        if (i_rst_n && product_ch.valid && product_ch.ready)
            products.check_result('{product_ch.product_value, product_ch.out_row,
                                    product_ch.out_col, product_ch.last_result});
    end

    // Watchdog: end the run when neither channel has moved for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pair_ch.valid && pair_ch.ready) || (product_ch.valid && product_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic t_sword pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return t_sword'($urandom_range(0, 8)) - 4;
            default: return t_sword'($urandom);
        endcase
    endfunction

    // Keep sizes mostly small; a large value covers 8 and the clamp above it.
    function automatic t_dim pick_size(bit go_large);
        if (go_large) return t_dim'($urandom_range(8, 15));
        return ($urandom_range(0, 9) == 0) ? t_dim'(0) : t_dim'($urandom_range(1, 3));
    endfunction

    // Length of one side: usually exact, sometimes with dropped extras, and
    // short only when every entry left out already holds a written value.
    function automatic int side_length(int need, logic [STORE_DEPTH-1:0] written);
        int covered_from;
        covered_from = need;
        while (covered_from > 1 && written[covered_from-1]) covered_from--;
        case ($urandom_range(0, 7))
            0: if (covered_from < need) return $urandom_range(covered_from, need - 1);
            1: return need + $urandom_range(1, 3);
            default: ;
        endcase
        return need;
    endfunction

    // Present one pair at a falling edge, hold it until the block takes it,
    // then note the transaction. Valid stays high for a back-to-back follower.
    task automatic send_pair(t_pair p);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pair_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pair_ch.valid        = 1'b1;
        pair_ch.side         = p.side;
        pair_ch.first_value  = p.first_value;
        pair_ch.second_value = p.second_value;
        pair_ch.last_of_side = p.last_of_side;
        do @(posedge i_clk); while (!pair_ch.ready);
        products.note_pair(p);
    endtask

    task automatic send_run(logic side, int count, bit close);
        for (int n = 0; n < count; n++)
            send_pair('{side, pick_value(), pick_value(), close && (n == count - 1)});
    endtask

    // Drop valid, wait for every expected element, then let the pipeline empty.
    task automatic settle();
        @(negedge i_clk);
        pair_ch.valid = 1'b0;
        while (products.expected_elems.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_size(t_cfg_idx idx, t_dim value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        products.set_size(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One job at the sizes in force: a left side, and unless it is left-only,
    // a right side whose closing pair starts the product. Mixed jobs interleave
    // the two sides; they run only when all entries the product reads are written.
    task automatic run_job(bit with_product, bit mixed);
        t_pair left_q [$];
        t_pair right_q [$];
        int    n_left;
        int    n_right;
        n_left = side_length(products.left_need(), products.left_written);
        for (int n = 0; n < n_left; n++)
            left_q.push_back('{SIDE_LEFT, pick_value(), pick_value(), n == n_left - 1});
        if (with_product) begin
            n_right = side_length(products.right_need(), products.right_written);
            for (int n = 0; n < n_right; n++)
                right_q.push_back('{SIDE_RIGHT, pick_value(), pick_value(),
                                    n == n_right - 1});
        end
        while (left_q.size() != 0 || right_q.size() != 0) begin
            if (right_q.size() == 0 ||
                (left_q.size() != 0 && (!mixed || $urandom_range(0, 1) == 1)))
                send_pair(left_q.pop_front());
            else
                send_pair(right_q.pop_front());
            random_pairs++;
        end
    endtask

    initial begin
        logic [STORE_DEPTH-1:0] left_mask;
        logic [STORE_DEPTH-1:0] right_mask;
        int                     large_reg;
        int                     kind;
        bit                     covered;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_ROW_COUNT;
        i_cfg_data           = DIM_RESET;
        pair_ch.valid        = 1'b0;
        pair_ch.side         = SIDE_LEFT;
        pair_ch.first_value  = '0;
        pair_ch.second_value = '0;
        pair_ch.last_of_side = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 1x1x1 with extreme operands: both sums and the product wrap.
        write_size(REG_ROW_COUNT, 4'd1);
        write_size(REG_INNER_COUNT, 4'd1);
        write_size(REG_COL_COUNT, 4'd1);
        send_pair('{SIDE_LEFT, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1});
        send_pair('{SIDE_RIGHT, 32'sh8000_0000, -32'sd1, 1'b1});

        // Zero sizes act as 1, 15 acts as MAX_DIM: a 1x1x8 product. The second
        // left pair overflows the store and is dropped, but still closes the side.
        settle();
        write_size(REG_ROW_COUNT, 4'd0);
        write_size(REG_INNER_COUNT, 4'd0);
        write_size(REG_COL_COUNT, 4'd15);
        send_run(SIDE_LEFT, 2, 1'b1);
        send_run(SIDE_RIGHT, 8, 1'b1);

        // Short right side: entries past the close keep their old sums.
        settle();
        write_size(REG_COL_COUNT, 4'd4);
        send_run(SIDE_LEFT, 1, 1'b1);
        send_run(SIDE_RIGHT, 2, 1'b1);

        // Resize in the middle of loading, with the left side still open
        // across the product; its close then comes as a dropped pair.
        settle();
        write_size(REG_COL_COUNT, 4'd2);
        send_run(SIDE_LEFT, 1, 1'b0);
        send_run(SIDE_RIGHT, 1, 1'b0);
        settle();
        write_size(REG_COL_COUNT, 4'd3);
        send_run(SIDE_RIGHT, 1, 1'b1);
        send_run(SIDE_LEFT, 1, 1'b1);

        // 8x1x8: full row and column index range; short right side of one pair.
        settle();
        write_size(REG_ROW_COUNT, 4'd8);
        write_size(REG_COL_COUNT, 4'd8);
        send_run(SIDE_LEFT, 8, 1'b1);
        send_run(SIDE_RIGHT, 1, 1'b1);

        // Random jobs; advance the idle pattern by thirds of the run.
        random_pairs = 0;
        while (random_pairs < RANDOM_PAIRS) begin
            if (random_pairs >= 2 * RANDOM_PAIRS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_pairs >= RANDOM_PAIRS / 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 24;
            end
            // Resize most of the time; otherwise let the next job overlap the
            // product still draining.
            if ($urandom_range(0, 2) != 0) begin
                settle();
                large_reg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : -1;
                if ($urandom_range(0, 1) == 1)
                    write_size(REG_ROW_COUNT, pick_size(large_reg == 0));
                if ($urandom_range(0, 1) == 1)
                    write_size(REG_INNER_COUNT, pick_size(large_reg == 1));
                if ($urandom_range(0, 1) == 1)
                    write_size(REG_COL_COUNT, pick_size(large_reg == 2));
            end
            left_mask  = {STORE_DEPTH{1'b1}} >> (STORE_DEPTH - products.left_need());
            right_mask = {STORE_DEPTH{1'b1}} >> (STORE_DEPTH - products.right_need());
            covered    = ((products.left_written & left_mask) == left_mask) &&
                         ((products.right_written & right_mask) == right_mask);
            kind = $urandom_range(0, 9);
            run_job(kind != 0, covered && kind <= 2);
        end

        settle();
        if (products.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/msp_pkg.sv
hw/rtl/msp_in_if.sv
hw/rtl/msp_out_if.sv
hw/rtl/msp_ctrl.sv
hw/rtl/msp_dp.sv
hw/rtl/matrix_sum_product_top.sv
tb/matrix_sum_product_top_tb.sv
